// ===== rtl/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and constants of the stick direction qualifier
// Request payloads, configuration register indexes, reset values, FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdq_pkg;

  // input request: one stick sample or a clear
  typedef struct packed {
    logic               operation;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [9:0]         elapsed_ms;
    logic               active;
  } sdq_in_t;

  // result request: discrete moves
  typedef struct packed {
    logic move_left;
    logic move_right;
    logic rotate_req;
    logic drop_req;
  } sdq_out_t;

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ON_THRESHOLD  = 3'd0,
    CFG_OFF_THRESHOLD = 3'd1,
    CFG_CROSS_LIMIT   = 3'd2,
    CFG_DEAD_ZONE     = 3'd3,
    CFG_AXIS_RATIO    = 3'd4,
    CFG_REPEAT_DELAY  = 3'd5,
    CFG_REPEAT_PERIOD = 3'd6,
    CFG_VERT_GAP_MS   = 3'd7
  } sdq_cfg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  // register reset values
  localparam logic [14:0] OnThreshRst   = 15'd8192;
  localparam logic [14:0] OffThreshRst  = 15'd3932;
  localparam logic [14:0] CrossLimitRst = 15'd5571;
  localparam logic [14:0] DeadZoneRst   = 15'd1638;
  localparam logic [9:0]  AxisRatioRst  = 10'd404;
  localparam logic [7:0]  RepDelayRst   = 8'd16;
  localparam logic [7:0]  RepPeriodRst  = 8'd7;
  localparam logic [11:0] VertGapRst    = 12'd260;

  localparam logic [15:0] SinceMax = 16'hFFFF;

  // serial multiplier geometry: 4-bit digits
  localparam int unsigned DigitW   = 4;
  localparam int unsigned LaneW    = 40;
  localparam int unsigned SqW      = 31;
  localparam int unsigned SqDigits = 4;
  localparam int unsigned RatioDig = 3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SQUARE = 2'd1,
    ST_SCALE  = 2'd2,
    ST_DECIDE = 2'd3
  } sdq_state_e;

endpackage

// ===== rtl/sdq_stream_if.sv =====
// ----------------------------------------------------------------------------
// sdq_stream_if: valid/ready channel
// Carries one payload per accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/stick_direction_qualifier.sv =====
// ----------------------------------------------------------------------------
// stick_direction_qualifier: stick sample to left/right/rotate/drop requests
// Dead zone, dominant-axis test on squared deflections, hysteresis,
// cross-axis limit, horizontal auto-repeat and vertical spacing.
// ----------------------------------------------------------------------------
//  channel   dir  payload     handshake
//  in_i      in   sdq_in_t    valid/ready, one sample or clear per request
//  out_o     out  sdq_out_t   valid/ready, one result per input request
//  cfg_*     in   15-bit data write enable, no back-pressure
//
//  each request passes an accept in idle, 4 radix-16 digit steps for the two
//  squares, 3 digit steps for the ratio products and a decision step
//  the two 40-bit serial multiply lanes carry out the digit steps
//  a new request is accepted when the sequencer is idle; a result waiting in
//  the output register stalls only the decision cycle
//  reset is asynchronous active low and restores config, state and latches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stick_direction_qualifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sdq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sdq_pkg::CfgDataW-1:0]  cfg_data_i,
  sdq_stream_if.sink                    in_i,
  sdq_stream_if.source                  out_o
);

  typedef struct packed {
    logic       latch;
    logic [8:0] count;
    logic       move;
  } rep_t;

  // one horizontal direction of the auto-repeat phase counter
  function automatic rep_t repeat_step(logic want, logic latch, logic [8:0] count,
                                       logic [7:0] dly, logic [7:0] per);
    rep_t       r;
    logic [9:0] nxt;
    nxt     = {1'b0, count} + 10'd1;
    r.latch = 1'b1;
    r.count = count;
    r.move  = 1'b0;
    if (!want) begin
      r.latch = 1'b0;
      r.count = '0;
    end else if (!latch) begin
      r.count = 9'd1;
      r.move  = 1'b1;
    end else if (count <= {1'b0, dly}) begin
      r.count = nxt[8:0];
      r.move  = (count == {1'b0, dly});
    end else if (nxt > ({2'b00, dly} + {2'b00, per})) begin
      r.count = {1'b0, dly} + 9'd1;
      r.move  = 1'b1;
    end else begin
      r.count = nxt[8:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [14:0] on_thr_q, off_thr_q, cross_q, dead_q;
  logic [9:0]  ratio_q;
  logic [7:0]  rdelay_q, rperiod_q;
  logic [11:0] vgap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_thr_q  <= sdq_pkg::OnThreshRst;
      off_thr_q <= sdq_pkg::OffThreshRst;
      cross_q   <= sdq_pkg::CrossLimitRst;
      dead_q    <= sdq_pkg::DeadZoneRst;
      ratio_q   <= sdq_pkg::AxisRatioRst;
      rdelay_q  <= sdq_pkg::RepDelayRst;
      rperiod_q <= sdq_pkg::RepPeriodRst;
      vgap_q    <= sdq_pkg::VertGapRst;
    end else if (cfg_we_i) begin
      unique case (sdq_pkg::sdq_cfg_e'(cfg_idx_i))
        sdq_pkg::CFG_ON_THRESHOLD:  on_thr_q  <= cfg_data_i;
        sdq_pkg::CFG_OFF_THRESHOLD: off_thr_q <= cfg_data_i;
        sdq_pkg::CFG_CROSS_LIMIT:   cross_q   <= cfg_data_i;
        sdq_pkg::CFG_DEAD_ZONE:     dead_q    <= cfg_data_i;
        sdq_pkg::CFG_AXIS_RATIO:    ratio_q   <= cfg_data_i[9:0];
        sdq_pkg::CFG_REPEAT_DELAY:  rdelay_q  <= cfg_data_i[7:0];
        sdq_pkg::CFG_REPEAT_PERIOD: rperiod_q <= cfg_data_i[7:0];
        sdq_pkg::CFG_VERT_GAP_MS:   vgap_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // sequencer
  sdq_pkg::sdq_state_e state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                in_acc, commit, out_free;
  logic                sq_last, sc_last;

  assign out_free = !out_o.valid || out_o.ready;
  assign in_i.ready = (state_q == sdq_pkg::ST_IDLE);
  assign in_acc   = in_i.valid && in_i.ready;
  assign sq_last  = (cnt_q == 2'(sdq_pkg::SqDigits - 1));
  assign sc_last  = (cnt_q == 2'(sdq_pkg::RatioDig - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    commit  = 1'b0;
    unique case (state_q)
      sdq_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_acc) state_d = sdq_pkg::ST_SQUARE;
      end
      sdq_pkg::ST_SQUARE: begin
        cnt_d = cnt_q + 2'd1;
        if (sq_last) begin
          cnt_d   = '0;
          state_d = sdq_pkg::ST_SCALE;
        end
      end
      sdq_pkg::ST_SCALE: begin
        cnt_d = cnt_q + 2'd1;
        if (sc_last) begin
          cnt_d   = '0;
          state_d = sdq_pkg::ST_DECIDE;
        end
      end
      sdq_pkg::ST_DECIDE: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = sdq_pkg::ST_IDLE;
        end
      end
      default: state_d = sdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdq_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // captured request
  logic               op_q, act_q;
  logic signed [15:0] x_q, y_q;
  logic [9:0]         el_q;
  logic [15:0]        ax_q, ay_q;
  logic [15:0]        ax_in, ay_in;

  assign ax_in = in_i.payload.x_pos[15] ? 16'(-in_i.payload.x_pos) : in_i.payload.x_pos;
  assign ay_in = in_i.payload.y_pos[15] ? 16'(-in_i.payload.y_pos) : in_i.payload.y_pos;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.payload.operation;
      act_q <= in_i.payload.active;
      x_q   <= in_i.payload.x_pos;
      y_q   <= in_i.payload.y_pos;
      el_q  <= in_i.payload.elapsed_ms;
      ax_q  <= ax_in;
      ay_q  <= ay_in;
    end
  end

  // two serial multiply lanes: multiplicand shifts up, multiplier shifts down
  logic [sdq_pkg::LaneW-1:0] mc_x_q, mc_y_q, acc_x_q, acc_y_q;
  logic [sdq_pkg::LaneW-1:0] acc_x_nx, acc_y_nx;
  logic [15:0]               mp_x_q, mp_y_q;
  logic [sdq_pkg::SqW-1:0]   sq_x_q, sq_y_q;

  assign acc_x_nx = acc_x_q + mc_x_q * sdq_pkg::LaneW'(mp_x_q[sdq_pkg::DigitW-1:0]);
  assign acc_y_nx = acc_y_q + mc_y_q * sdq_pkg::LaneW'(mp_y_q[sdq_pkg::DigitW-1:0]);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mc_x_q  <= sdq_pkg::LaneW'(ax_in);
      mc_y_q  <= sdq_pkg::LaneW'(ay_in);
      mp_x_q  <= ax_in;
      mp_y_q  <= ay_in;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (state_q == sdq_pkg::ST_SQUARE && sq_last) begin
      // squares done: keep them and start the ratio products
      sq_x_q  <= acc_x_nx[sdq_pkg::SqW-1:0];
      sq_y_q  <= acc_y_nx[sdq_pkg::SqW-1:0];
      mc_x_q  <= acc_x_nx;
      mc_y_q  <= acc_y_nx;
      mp_x_q  <= 16'(ratio_q);
      mp_y_q  <= 16'(ratio_q);
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (state_q == sdq_pkg::ST_SQUARE || state_q == sdq_pkg::ST_SCALE) begin
      mc_x_q  <= mc_x_q << sdq_pkg::DigitW;
      mc_y_q  <= mc_y_q << sdq_pkg::DigitW;
      mp_x_q  <= mp_x_q >> sdq_pkg::DigitW;
      mp_y_q  <= mp_y_q >> sdq_pkg::DigitW;
      acc_x_q <= acc_x_nx;
      acc_y_q <= acc_y_nx;
    end
  end

  // discrete state
  logic       lat_l_q, lat_r_q, lat_u_q, lat_d_q;
  logic       lat_l_d, lat_r_d, lat_u_d, lat_d_d;
  logic [8:0] cnt_l_q, cnt_r_q, cnt_l_d, cnt_r_d;
  logic [15:0] since_q, since_d;
  sdq_pkg::sdq_out_t res;

  logic [16:0] since_sum;
  logic [15:0] since_adv;
  logic        dead, horiz, vert, cross_h, cross_v, gap_ok;
  logic [14:0] tl, tr, tu, td;
  logic signed [16:0] xs, ys;
  logic        wl, wr, wu, wd;
  rep_t        rep_l, rep_r;

  assign since_sum = {1'b0, since_q} + 17'(el_q);
  assign since_adv = since_sum[16] ? sdq_pkg::SinceMax : since_sum[15:0];
  assign dead      = (ax_q < 16'(dead_q)) && (ay_q < 16'(dead_q));
  assign horiz     = {1'b0, sq_x_q, 8'h00} >= acc_y_q;
  assign vert      = {1'b0, sq_y_q, 8'h00} >= acc_x_q;
  assign cross_h   = ay_q < 16'(cross_q);
  assign cross_v   = ax_q < 16'(cross_q);
  assign gap_ok    = since_adv >= 16'(vgap_q);
  assign tl        = lat_l_q ? off_thr_q : on_thr_q;
  assign tr        = lat_r_q ? off_thr_q : on_thr_q;
  assign tu        = lat_u_q ? off_thr_q : on_thr_q;
  assign td        = lat_d_q ? off_thr_q : on_thr_q;
  assign xs        = 17'(x_q);
  assign ys        = 17'(y_q);
  assign wl        = (xs <= -$signed({2'b00, tl})) && cross_h;
  assign wr        = (xs >= $signed({2'b00, tr})) && cross_h;
  assign wu        = (ys >= $signed({2'b00, tu})) && cross_v;
  assign wd        = (ys <= -$signed({2'b00, td})) && cross_v;
  assign rep_l     = repeat_step(wl, lat_l_q, cnt_l_q, rdelay_q, rperiod_q);
  assign rep_r     = repeat_step(wr, lat_r_q, cnt_r_q, rdelay_q, rperiod_q);

  // decision on the captured sample
  always_comb begin
    lat_l_d = lat_l_q;
    lat_r_d = lat_r_q;
    lat_u_d = lat_u_q;
    lat_d_d = lat_d_q;
    cnt_l_d = cnt_l_q;
    cnt_r_d = cnt_r_q;
    since_d = since_adv;
    res     = '0;
    priority if (op_q == sdq_pkg::OP_CLEAR || (act_q && (dead || (!horiz && !vert)))) begin
      lat_l_d = 1'b0;
      lat_r_d = 1'b0;
      lat_u_d = 1'b0;
      lat_d_d = 1'b0;
      cnt_l_d = '0;
      cnt_r_d = '0;
      since_d = sdq_pkg::SinceMax;
    end else if (!act_q) begin
      // time only
    end else if (horiz) begin
      lat_u_d        = 1'b0;
      lat_d_d        = 1'b0;
      lat_l_d        = rep_l.latch;
      cnt_l_d        = rep_l.count;
      lat_r_d        = rep_r.latch;
      cnt_r_d        = rep_r.count;
      res.move_left  = rep_l.move;
      res.move_right = rep_r.move;
    end else begin
      lat_l_d = 1'b0;
      lat_r_d = 1'b0;
      cnt_l_d = '0;
      cnt_r_d = '0;
      if (!y_q[15]) begin
        lat_d_d = 1'b0;
        if (!wu) begin
          lat_u_d = 1'b0;
        end else if (!lat_u_q && gap_ok) begin
          lat_u_d        = 1'b1;
          since_d        = '0;
          res.rotate_req = 1'b1;
        end
      end else begin
        lat_u_d = 1'b0;
        if (!wd) begin
          lat_d_d = 1'b0;
        end else if (!lat_d_q && gap_ok) begin
          lat_d_d      = 1'b1;
          since_d      = '0;
          res.drop_req = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_l_q <= 1'b0;
      lat_r_q <= 1'b0;
      lat_u_q <= 1'b0;
      lat_d_q <= 1'b0;
      cnt_l_q <= '0;
      cnt_r_q <= '0;
      since_q <= sdq_pkg::SinceMax;
    end else if (commit) begin
      lat_l_q <= lat_l_d;
      lat_r_q <= lat_r_d;
      lat_u_q <= lat_u_d;
      lat_d_q <= lat_d_d;
      cnt_l_q <= cnt_l_d;
      cnt_r_q <= cnt_r_d;
      since_q <= since_d;
    end
  end

  // output register
  logic              out_vld_q;
  sdq_pkg::sdq_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (commit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) out_data_q <= res;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_data_q;

endmodule
